### rtl/radix_digit_converter_unit_defines.svh
// Assertion macros used by the radix digit converter top level.
`ifndef RADIX_DIGIT_CONVERTER_UNIT_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define RDC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rdc assertion failed: condition does not hold");

// Check that a consequent holds in the same cycle as its antecedent.
`define RDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdc assertion failed: implication does not hold");

// Check that a consequent holds in the cycle after its antecedent.
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdc assertion failed: next-cycle implication does not hold");

`endif

### rtl/rdc_pkg.sv
// Shared constants and types for the radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    typedef logic [2:0] radix_t;
    typedef logic [5:0] char_t;

    localparam int     DEFAULT_VALUE_BITS = 31;
    localparam int     DEFAULT_MAX_DIGITS = 20;
    localparam int     CHUNK_BITS         = 8;
    localparam int     QUEUE_DEPTH        = 2;

    localparam radix_t RADIX_MIN  = 3'd3;
    localparam radix_t RADIX_MAX  = 3'd6;
    localparam char_t  ASCII_ZERO = 6'd48;

endpackage

`default_nettype wire

### rtl/radix_digit_converter_unit.sv
// Top level of the radix digit converter: config register, front, back, result queue.
`timescale 1ns / 1ps
`default_nettype none

`include "radix_digit_converter_unit_defines.svh"

// Radix digit converter. Push a non-negative integer on value; it comes back
// as ASCII digits '0'..'5' in the configured radix (3 to 6), most significant
// digit first, one result transaction per digit, with last_digit set on the
// least significant one. Zero gives the single digit '0'. Write cfg_radix only
// while no conversion is in flight; values below 3 are stored as 3 and values
// above 6 as 6. The back end loads a value, then divides it by the radix one
// 8-bit chunk per cycle, starting at the highest nonzero chunk of the running
// quotient, stacks one digit per pass, and emits the stacked digits while the
// result queue has room; it takes the next value only once the last is out.
// A two-entry input queue lets the next values be pushed while one converts,
// and a two-entry result queue holds digits while pop is low. More than
// MAX_DIGITS digits keeps only the least significant MAX_DIGITS.
module radix_digit_converter_unit
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire radix_t                cfg_radix,
    // input queue side
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [VALUE_BITS-1:0] value,
    // result queue side
    output logic                       empty,
    input  wire logic                  pop,
    output char_t                      digit_char,
    output logic                       last_digit
);

    localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int CI_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int RES_W  = $bits(char_t) + 1;

    radix_t                  radix_reg, radix_next;
    logic                    item_pop;
    logic                    item_empty;
    logic [VALUE_BITS-1:0]   item_value;
    logic [CI_W-1:0]         item_top;
    logic                    res_full;
    logic                    res_push;
    char_t                   res_char;
    logic                    res_last;
    logic [RES_W-1:0]        res_rd;

    // The register is always ready; saturate the written radix into 3..6.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_radix < RADIX_MIN)
            begin
                radix_next = RADIX_MIN;
            end
            else if (cfg_radix > RADIX_MAX)
            begin
                radix_next = RADIX_MAX;
            end
            else
            begin
                radix_next = cfg_radix;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_MIN;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // Accept and tag values, then queue them for the divider.
    rdc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .item_pop   (item_pop),
        .item_empty (item_empty),
        .item_value (item_value),
        .item_top   (item_top)
    );

    // Divide, stack the digits, and emit them most significant first.
    rdc_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .radix      (radix_reg),
        .item_empty (item_empty),
        .item_value (item_value),
        .item_top   (item_top),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_char   (res_char),
        .res_last   (res_last)
    );

    // Hold finished digits until the consumer pops them.
    rdc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data ({res_char, res_last}),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign digit_char = res_rd[RES_W-1:1];
    assign last_digit = res_rd[0];

    // The stored radix never leaves the legal range.
    `RDC_ASSERT_ALWAYS(a_radix_legal, clk, rst_n, (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX))
    // The back end only pushes a digit when the result queue has room.
    `RDC_ASSERT_SAME(a_res_push_room, clk, rst_n, res_push, !res_full)
    // The back end only takes a value that the front has queued.
    `RDC_ASSERT_SAME(a_item_pop_valid, clk, rst_n, item_pop, !item_empty)
    // An accepted value is visible to the back end on the next cycle.
    `RDC_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !full, !item_empty)

endmodule

`default_nettype wire

### rtl/rdc_fifo.sv
// Small show-ahead queue, used for the converter's input queue and its result queue.
`timescale 1ns / 1ps
`default_nettype none

module rdc_fifo
    import rdc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/rdc_front.sv
// Front stage: accept values, tag the highest nonzero chunk, queue them.
`timescale 1ns / 1ps
`default_nettype none

module rdc_front
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
    localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS,
    localparam int CI_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic                  item_pop,
    output logic                       item_empty,
    output logic      [VALUE_BITS-1:0] item_value,
    output logic      [CI_W-1:0]       item_top
);

    localparam int W      = NCHUNK * CHUNK_BITS;
    localparam int ITEM_W = VALUE_BITS + CI_W;

    logic [W-1:0]      padded;
    logic [CI_W-1:0]   top_chunk;
    logic [ITEM_W-1:0] wr_item;
    logic [ITEM_W-1:0] rd_item;

    // Find the most significant chunk that holds a one; zero maps to chunk 0.
    always_comb
    begin
        padded    = W'(value);
        top_chunk = '0;
        for (int c = 0; c < NCHUNK; c++)
        begin
            if (|padded[c*CHUNK_BITS +: CHUNK_BITS])
            begin
                top_chunk = CI_W'(c);
            end
        end
    end

    assign wr_item    = {top_chunk, value};
    assign item_value = rd_item[VALUE_BITS-1:0];
    assign item_top   = rd_item[ITEM_W-1:VALUE_BITS];

    rdc_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (wr_item),
        .full    (full),
        .rd_en   (item_pop),
        .rd_data (rd_item),
        .empty   (item_empty)
    );

endmodule

`default_nettype wire

### rtl/rdc_back.sv
// Back stage: chunk-serial division by the radix, digit stack, MSD-first emission.
`timescale 1ns / 1ps
`default_nettype none

module rdc_back
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
    localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS,
    localparam int CI_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire radix_t                radix,
    input  wire logic                  item_empty,
    input  wire logic [VALUE_BITS-1:0] item_value,
    input  wire logic [CI_W-1:0]       item_top,
    output logic                       item_pop,
    input  wire logic                  res_full,
    output logic                       res_push,
    output char_t                      res_char,
    output logic                       res_last
);

    localparam int W     = NCHUNK * CHUNK_BITS;
    localparam int IDX_W = $clog2(MAX_DIGITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [W-1:0]          quo_reg, quo_next;
    logic [2:0]            rem_reg, rem_next;
    logic [CI_W-1:0]       chunk_reg, chunk_next;
    logic [CI_W-1:0]       top_reg, top_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [2:0]            digit_mem [MAX_DIGITS];
    logic [2:0]            rd_data_reg;
    logic                  mem_we;

    logic [CHUNK_BITS-1:0] chunk_in;
    logic [CHUNK_BITS-1:0] quo_chunk;
    logic [3:0]            part;
    logic [2:0]            rem_new;
    logic [W-1:0]          quo_new;
    logic [CI_W-1:0]       top_dec;

    // One chunk of long division per cycle; the remainder stays below the radix.
    always_comb
    begin
        chunk_in  = quo_reg[chunk_reg*CHUNK_BITS +: CHUNK_BITS];
        part      = {1'b0, rem_reg};
        quo_chunk = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            part = {part[2:0], chunk_in[i]};
            if (part >= {1'b0, radix})
            begin
                part         = part - {1'b0, radix};
                quo_chunk[i] = 1'b1;
            end
        end
        rem_new = part[2:0];
        quo_new = quo_reg;
        quo_new[chunk_reg*CHUNK_BITS +: CHUNK_BITS] = quo_chunk;
    end

    // A divide by at most six drops the top nonzero chunk by at most one.
    assign top_dec = ((top_reg != '0) && (quo_new[top_reg*CHUNK_BITS +: CHUNK_BITS] == '0))
                     ? top_reg - 1'b1 : top_reg;

    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        top_next   = top_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        item_pop   = 1'b0;
        res_push   = 1'b0;
        mem_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!item_empty)
                begin
                    item_pop   = 1'b1;
                    quo_next   = W'(item_value);
                    rem_next   = '0;
                    chunk_next = item_top;
                    top_next   = item_top;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = quo_new;
                if (chunk_reg == '0)
                begin
                    mem_we = 1'b1;
                    if ((quo_new == '0) || (cnt_reg == IDX_W'(MAX_DIGITS - 1)))
                    begin
                        idx_next   = cnt_reg;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        rem_next   = '0;
                        top_next   = top_dec;
                        chunk_next = top_dec;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    rem_next   = rem_new;
                    chunk_next = chunk_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_char = ASCII_ZERO + char_t'(rd_data_reg);
    assign res_last = (idx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
            top_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            top_reg   <= top_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // Digit stack: write at the digit count, read ahead at the next emit index.
    // Forward the digit being written when both land on the same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[cnt_reg] <= rem_new;
        end
        if (mem_we && (cnt_reg == idx_next))
        begin
            rd_data_reg <= rem_new;
        end
        else
        begin
            rd_data_reg <= digit_mem[idx_next];
        end
    end

endmodule

`default_nettype wire

### dv/rdc_digit_checker.sv
// Digit predictor and scoreboard for the radix digit converter.
`timescale 1ns / 1ps

module rdc_digit_checker
    import rdc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  radix_t                        cfg_radix,
    input  logic                          push,
    input  logic                          full,
    input  logic [DEFAULT_VALUE_BITS-1:0] value,
    input  logic                          empty,
    input  logic                          pop,
    input  char_t                         digit_char,
    input  logic                          last_digit,
    output int                            mismatches,
    output int                            digits_owed
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        char_t digit_char;
        logic  last_digit;
    } digit_t;

    radix_t base = RADIX_MIN;
    digit_t digit_queue[$];

    initial
    begin
        mismatches  = 0;
        digits_owed = 0;
    end

    // Queue the digits of one value, most significant first.
    function automatic void queue_digits_of(input logic [DEFAULT_VALUE_BITS-1:0] v);
        int unsigned     rev_digits [DEFAULT_MAX_DIGITS];
        longint unsigned rest;
        int              count;
        digit_t          d;
        rest  = 64'(v);
        count = 0;
        do
        begin
            rev_digits[count] = int'(rest % base);
            rest              = rest / base;
            count++;
        end
        while (rest != 0 && count < DEFAULT_MAX_DIGITS);
        for (int k = count - 1; k >= 0; k--)
        begin
            d.digit_char = ASCII_ZERO + char_t'(rev_digits[k]);
            d.last_digit = (k == 0);
            digit_queue.push_back(d);
        end
    endfunction

    task automatic report_mismatch(input string what, input digit_t want);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected char %0d last %0b, got char %0d last %0b",
                     $realtime, what, want.digit_char, want.last_digit,
                     digit_char, last_digit);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base = RADIX_MIN;
            digit_queue.delete();
        end
        else
        begin
            // check the result transaction before queueing this edge's input
            if (pop && !empty)
            begin
                if (digit_queue.size() == 0)
                    report_mismatch("unexpected digit", '0);
                else if (digit_char !== digit_queue[0].digit_char ||
                         last_digit !== digit_queue[0].last_digit)
                    report_mismatch("digit mismatch", digit_queue.pop_front());
                else
                    void'(digit_queue.pop_front());
            end
            // saturate the radix into the supported range on write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_radix < RADIX_MIN)
                    base = RADIX_MIN;
                else if (cfg_radix > RADIX_MAX)
                    base = RADIX_MAX;
                else
                    base = cfg_radix;
            end
            if (push && !full)
                queue_digits_of(value);
        end
        digits_owed = digit_queue.size();
    end

endmodule

### dv/tb_radix_digit_converter_unit.sv
// Stimulus, handshake pacing and verdict for the radix digit converter.
`timescale 1ns / 1ps

module tb_radix_digit_converter_unit;
    import rdc_pkg::*;

    localparam int VBITS          = DEFAULT_VALUE_BITS;
    localparam int RESET_CYCLES   = 6;
    // Allow a wide margin over the slowest conversion and the long pop
    // hold-off before declaring the block hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 120;
    localparam int PHASE_ITEMS    = 45;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    radix_t           cfg_radix = '0;
    logic             push      = 1'b0;
    logic             full;
    logic [VBITS-1:0] value     = '0;
    logic             empty;
    logic             pop       = 1'b0;
    char_t            digit_char;
    logic             last_digit;

    int mismatches;
    int digits_owed;

    // Pacing controls for the sender and the receiver, and the watchdog count.
    bit quiet_tail    = 1'b0;
    int hold_requests = 0;
    int hold_served   = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;

    always #5 clk = ~clk;

    radix_digit_converter_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_radix  (cfg_radix),
        .push       (push),
        .full       (full),
        .value      (value),
        .empty      (empty),
        .pop        (pop),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    rdc_digit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_radix   (cfg_radix),
        .push        (push),
        .full        (full),
        .value       (value),
        .empty       (empty),
        .pop         (pop),
        .digit_char  (digit_char),
        .last_digit  (last_digit),
        .mismatches  (mismatches),
        .digits_owed (digits_owed)
    );

    // Receiver: pop every cycle except during random stall bursts or a long
    // hold-off when the stimulus asks for one. The hold counts down here so
    // the sender keeps offering values meanwhile and the block backs up into
    // full.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left != 0)
        begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            pop         <= 1'b0;
            stall_left  <= LONG_HOLD - 1;
            hold_served <= hold_requests;
        end
        else if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            pop        <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end
        else
            pop <= 1'b1;
    end

    // Watchdog: end the run once nothing has moved on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one value; hold it until the block takes it. Insert a random
    // idle burst ahead of it unless the run is in its quiet tail.
    task automatic send_one(input logic [VBITS-1:0] v);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        push  <= 1'b1;
        value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Drop push and wait until every queued digit has been popped. Every value
    // yields at least one digit, so an empty scoreboard means an idle block;
    // a few extra cycles cover the last pop settling.
    task automatic drain;
        push <= 1'b0;
        @(negedge clk);
        wait (digits_owed == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the radix register once the block has gone idle.
    task automatic write_radix(input radix_t r);
        drain();
        cfg_valid <= 1'b1;
        cfg_radix <= r;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        radix_t           phase_radix [8];
        radix_t           eff;
        longint unsigned  pw;
        logic [VBITS-1:0] v;

        // Out-of-range radix codes (0, 1, 2, 7) exercise write saturation.
        phase_radix = '{3'd7, 3'd0, 3'd5, 3'd3, 3'd1, 3'd4, 3'd6, 3'd2};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset radix of 3: zero, single digits, the carry into a
        // second digit, the widest value (twenty digits), and around 3^19.
        send_one(31'd0);
        send_one(31'd1);
        send_one(31'd2);
        send_one(31'd3);
        send_one(31'd1162261466);
        send_one(31'd1162261467);
        send_one(31'h7FFF_FFFF);
        send_one(31'h5555_5555);
        send_one(31'h2AAA_AAAA);

        // Directed, radix 6: top digit '5', the first two-digit value, 6^11.
        write_radix(3'd6);
        send_one(31'd0);
        send_one(31'd5);
        send_one(31'd6);
        send_one(31'd362797056);
        send_one(31'h7FFF_FFFF);

        // Directed, radix 4 and 5 around their largest powers.
        write_radix(3'd4);
        send_one(31'd3);
        send_one(31'h4000_0000);
        send_one(31'h3FFF_FFFF);
        write_radix(3'd5);
        send_one(31'd4);
        send_one(31'd1220703125);

        // Random phases, one radix setting each.
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
                quiet_tail = 1'b1;
            write_radix(phase_radix[p]);
            if (phase_radix[p] < RADIX_MIN)
                eff = RADIX_MIN;
            else if (phase_radix[p] > RADIX_MAX)
                eff = RADIX_MAX;
            else
                eff = phase_radix[p];
            // Hold off the receiver once so the block fills and stalls push.
            if (p == 3)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = VBITS'($urandom_range(0, 300));
                    4, 5:
                    begin
                        // land on or next to a power of the radix
                        pw = 1;
                        repeat ($urandom_range(1, 19))
                            if (pw * eff <= 64'h7FFF_FFFF)
                                pw = pw * eff;
                        v = VBITS'(pw - 1 + $urandom_range(0, 2));
                    end
                    default: v = VBITS'($urandom);
                endcase
                send_one(v);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (digits_owed != 0)
            $display("%0d expected digits never arrived", digits_owed);
        if (mismatches == 0 && digits_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
